// ===== sv/alarm_window_evaluator_macros.svh =====
// Assertion helpers for the alarm window evaluator.
// Every macro samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef ALARM_WINDOW_EVALUATOR_MACROS_SVH
`define ALARM_WINDOW_EVALUATOR_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define AWE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alarm window evaluator: assertion failed");

// Next-cycle implication.
`define AWE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alarm window evaluator: assertion failed");

`else

`define AWE_ASSERT_IMP(lbl, ante, cons)
`define AWE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/awe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package awe_pkg;

	// Default table depth.
	localparam int MAX_ENTRIES_DEF = 8;

	// Width of the entry counter and of the alarm_count register.
	localparam int CNT_W = 4;

	localparam int DATE_W = 16;
	localparam int TIME_W = 17;

	// One date-time bound, packed in the same order as the stored word.
	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} bound_t;

	// Operation codes. The fourth code is unused and is answered with both flags low.
	typedef enum logic [1:0] {
		OP_EVAL     = 2'd0,
		OP_WR_START = 2'd1,
		OP_WR_END   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	function automatic logic [DATE_W-1:0] date_of(input bound_t b);
		return {b.year, b.month, b.day};
	endfunction

	function automatic logic [TIME_W-1:0] time_of(input bound_t b);
		return {b.hour, b.minute, b.second};
	endfunction

endpackage

`default_nettype wire

// ===== sv/awe_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one beat is one operation with its date-time fields.
interface awe_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [2:0] entry_index;
	logic [6:0] year;
	logic [3:0] month;
	logic [4:0] day;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [5:0] second;

	modport source (
		output valid, operation, entry_index, year, month, day, hour, minute, second,
		input  ready
	);
	modport sink (
		input  valid, operation, entry_index, year, month, day, hour, minute, second,
		output ready
	);
endinterface

// Result channel: one beat per accepted operation.
interface awe_result_if;
	logic valid;
	logic ready;
	logic alarm_active;
	logic write_done;

	modport source (
		output valid, alarm_active, write_done,
		input  ready
	);
	modport sink (
		input  valid, alarm_active, write_done,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/awe_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Decides whether one alarm window covers the given date-time.
module awe_match (
	input  awe_pkg::bound_t start_bound,
	input  awe_pkg::bound_t end_bound,
	input  awe_pkg::bound_t now,
	output logic            covers
);
	import awe_pkg::*;

	logic [DATE_W-1:0] sd, ed, nd;
	logic [TIME_W-1:0] st, et, nt;

	assign sd = date_of(start_bound);
	assign ed = date_of(end_bound);
	assign nd = date_of(now);
	assign st = time_of(start_bound);
	assign et = time_of(end_bound);
	assign nt = time_of(now);

	always_comb begin
		priority if (sd == '0) begin
			// Daily window; a start later than the end wraps past midnight.
			if (st > et) begin
				covers = (nt >= st) || (nt <= et);
			end else begin
				covers = (nt >= st) && (nt < et);
			end
		end else if (sd == nd) begin
			covers = (nt >= st) && ((ed != nd) || (nt < et));
		end else if (ed == nd) begin
			covers = nt < et;
		end else begin
			covers = (nd >= sd) && (nd < ed);
		end
	end

endmodule

`default_nettype wire

// ===== sv/alarm_window_evaluator.sv =====
// Alarm window evaluator: a write beat's result beat is registered and appears the next cycle.
// An evaluate beat scans n entries at one per cycle from the bound memories, then goes through
// the drain state (skipped when n is 0) to the result state, n being alarm_count capped at the
// table depth; the next beat is taken after that. Throughput is bounded by the single read port
// of the bound memories. arst_n clears the control state, alarm_count and the per-entry valid
// bits, so every bound reads as zero until it is written.
`timescale 1ns / 1ps
`default_nettype none

`include "alarm_window_evaluator_macros.svh"

module alarm_window_evaluator #(
	parameter int MAX_ENTRIES = awe_pkg::MAX_ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     alarm_count_we,
	input  logic [awe_pkg::CNT_W-1:0] alarm_count_wdata,
	awe_item_if.sink                 item,
	awe_result_if.source             result
);
	import awe_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	// ------------------------------------------------------------------
	// Configuration register and its saturated entry count.
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] alarm_count_q;
	logic [CNT_W-1:0] n_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_count_q <= '0;
		end else if (alarm_count_we) begin
			alarm_count_q <= alarm_count_wdata;
		end
	end

	// Counts above the table depth scan the whole table.
	assign n_sat = (32'(alarm_count_q) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : alarm_count_q;

	// ------------------------------------------------------------------
	// Input beat decode.
	// ------------------------------------------------------------------
	state_t           state_q, state_d;
	logic             item_acc;
	logic             eval_acc;
	logic             wr_acc;
	logic             out_free;
	logic             wr_in_range;
	logic [IDX_W-1:0] wr_addr;
	bound_t           in_bound;

	assign in_bound = '{
		year:   item.year,
		month:  item.month,
		day:    item.day,
		hour:   item.hour,
		minute: item.minute,
		second: item.second
	};

	assign item_acc    = item.valid && item.ready;
	assign eval_acc    = item_acc && (op_t'(item.operation) == OP_EVAL);
	assign wr_acc      = item_acc && (op_t'(item.operation) == OP_WR_START ||
		op_t'(item.operation) == OP_WR_END);
	assign wr_in_range = 32'(item.entry_index) < MAX_ENTRIES;
	assign wr_addr     = IDX_W'(item.entry_index);

	// The result register is free when empty or when its beat leaves this cycle.
	assign out_free = !result.valid || result.ready;

	// ------------------------------------------------------------------
	// Scan registers.
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] n_q;
	bound_t           now_q;
	logic             hit_q;
	logic             last_entry;

	assign last_entry = (idx_q == (n_q - CNT_W'(1)));

	// ------------------------------------------------------------------
	// State machine: next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (eval_acc) begin
					// An empty scan goes straight to the result.
					state_d = (n_sat == '0) ? ST_RESULT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_entry) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// State machine: outputs.
	// ------------------------------------------------------------------
	logic start_we;
	logic end_we;
	logic rd_en;
	logic eval_start;
	logic res_load;
	logic res_active_d;
	logic res_done_d;

	always_comb begin
		item.ready   = 1'b0;
		start_we     = 1'b0;
		end_we       = 1'b0;
		rd_en        = 1'b0;
		eval_start   = 1'b0;
		res_load     = 1'b0;
		res_active_d = 1'b0;
		res_done_d   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = out_free;
				// A beat is taken here exactly when it is offered and the result is free.
				if (item.valid && out_free) begin
					unique case (op_t'(item.operation))
						OP_EVAL: begin
							eval_start = 1'b1;
						end
						OP_WR_START: begin
							start_we   = wr_in_range;
							res_load   = 1'b1;
							res_done_d = 1'b1;
						end
						OP_WR_END: begin
							end_we     = wr_in_range;
							res_load   = 1'b1;
							res_done_d = 1'b1;
						end
						default: begin
							// Unused operation code: answer with both flags low.
							res_load = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
			end
			ST_DRAIN: begin
				// The last entry read is being compared this cycle.
			end
			ST_RESULT: begin
				res_load     = out_free;
				res_active_d = hit_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			n_q   <= '0;
		end else if (eval_start) begin
			idx_q <= '0;
			n_q   <= n_sat;
		end else if (rd_en) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (eval_start) begin
			now_q <= in_bound;
		end
	end

	// ------------------------------------------------------------------
	// Bound memories. Writes are only taken in the idle state and reads
	// only during a scan, so the two never meet on the same entry and no
	// forwarding is needed. Valid bits stand in for the reset to zero.
	// ------------------------------------------------------------------
	bound_t           start_mem [MAX_ENTRIES];
	bound_t           end_mem   [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] start_vld_q;
	logic [MAX_ENTRIES-1:0] end_vld_q;
	logic [IDX_W-1:0] rd_addr;

	bound_t start_raw_s1;
	bound_t end_raw_s1;
	logic   start_ok_s1;
	logic   end_ok_s1;
	logic   rd_vld_s1;

	assign rd_addr = IDX_W'(idx_q);

	always_ff @(posedge clk) begin
		if (start_we) begin
			start_mem[wr_addr] <= in_bound;
		end
		if (end_we) begin
			end_mem[wr_addr] <= in_bound;
		end
		if (rd_en) begin
			start_raw_s1 <= start_mem[rd_addr];
			end_raw_s1   <= end_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_vld_q <= '0;
			end_vld_q   <= '0;
			start_ok_s1 <= 1'b0;
			end_ok_s1   <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (start_we) begin
				start_vld_q[wr_addr] <= 1'b1;
			end
			if (end_we) begin
				end_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				start_ok_s1 <= start_vld_q[rd_addr];
				end_ok_s1   <= end_vld_q[rd_addr];
			end
			rd_vld_s1 <= rd_en;
		end
	end

	// ------------------------------------------------------------------
	// Window check on the entry read last cycle, folded into hit_q.
	// ------------------------------------------------------------------
	bound_t start_eff;
	bound_t end_eff;
	logic   covers;

	assign start_eff = start_ok_s1 ? start_raw_s1 : '0;
	assign end_eff   = end_ok_s1   ? end_raw_s1   : '0;

	awe_match u_match (
		.start_bound (start_eff),
		.end_bound   (end_eff),
		.now         (now_q),
		.covers      (covers)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (eval_start) begin
			hit_q <= 1'b0;
		end else if (rd_vld_s1 && covers) begin
			hit_q <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result register: holds one beat so a waiting sink never stalls
	// the write path more than the handshake requires.
	// ------------------------------------------------------------------
	logic res_vld_q;
	logic res_active_q;
	logic res_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_load) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_active_q <= res_active_d;
			res_done_q   <= res_done_d;
		end
	end

	assign result.valid        = res_vld_q;
	assign result.alarm_active = res_active_q;
	assign result.write_done   = res_done_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`AWE_ASSERT_NEXT(a_write_acked, wr_acc, result.valid && result.write_done && !result.alarm_active)
	`AWE_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN, idx_q < n_q)
	`AWE_ASSERT_NEXT(a_empty_scan, eval_acc && n_sat == '0, state_q == ST_RESULT && !hit_q)
	`AWE_ASSERT_IMP(a_no_stray_read, state_q == ST_IDLE || state_q == ST_RESULT, !rd_vld_s1)

endmodule

`default_nettype wire
